>>> sv/assert_macros.svh
// assertion macros for the rtl top level
// expects clk_i and an active-low rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TTO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TTO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tto_pkg.sv
// types and constants for the triangle / tile overlap pipeline
// no dependencies; imported by every module of the block
package tto_pkg;

  localparam int CW            = 16;  // vertex coordinate width
  localparam int OW            = 12;  // tile origin width
  localparam int EW            = 17;  // edge vector and widened coordinate width
  localparam int TW            = 9;   // tile size width, holds up to 511
  localparam int PW            = 33;  // single product width
  localparam int DW            = 34;  // dot product width
  localparam int NE            = 3;   // triangle edges
  localparam int NSTG          = 5;   // pipeline register stages
  localparam int IN_DW         = 120;
  localparam int OUT_DW        = 8;
  localparam int TILE_SIZE_DEF = 16;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [DW-1:0] dot_t;

  typedef struct packed {
    coord_t [NE-1:0] vx;
    coord_t [NE-1:0] vy;
    logic [OW-1:0]   ox;
    logic [OW-1:0]   oy;
  } item_t;

  // edge axis k is the perpendicular of edge k -> k+1
  typedef struct packed {
    coord_t [NE-1:0] vx;
    coord_t [NE-1:0] vy;
    edge_t [NE-1:0]  ax;
    edge_t [NE-1:0]  ay;
    logic [OW-1:0]   ox;
    logic [OW-1:0]   oy;
    logic            sep_xy;
  } setup_t;

  typedef struct packed {
    prod_t [NE-1:0] pvx;  // vertex on the edge
    prod_t [NE-1:0] pvy;
    prod_t [NE-1:0] qvx;  // opposite vertex
    prod_t [NE-1:0] qvy;
    prod_t [NE-1:0] pox;  // tile origin
    prod_t [NE-1:0] poy;
    prod_t [NE-1:0] psx;  // tile size along the axis
    prod_t [NE-1:0] psy;
    logic           sep_xy;
  } mul_t;

  typedef struct packed {
    dot_t [NE-1:0] tri_p;
    dot_t [NE-1:0] tri_q;
    dot_t [NE-1:0] tile_lo;
    dot_t [NE-1:0] tile_hi;
    logic          sep_xy;
  } span_t;

endpackage

>>> sv/tto_setup.sv
// input register and edge setup stage: edge axes and the x / y axis test
// depends on tto_pkg
module tto_setup import tto_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic [1:0] en_i,
  input  item_t      item_i,
  output setup_t     setup_o
);

  localparam logic [TW-1:0] Size = TW'(TILE_SIZE);

  item_t  item_q;
  setup_t setup_d, setup_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      item_q <= item_i;
    end
    if (en_i[1]) begin
      setup_q <= setup_d;
    end
  end

  always_comb begin
    logic signed [EW-1:0] ox_e, oy_e, ox_far, oy_far;
    logic signed [EW-1:0] x0, x1, x2, y0, y1, y2;
    logic lo_x, hi_x, lo_y, hi_y;
    x0 = EW'($signed(item_q.vx[0]));
    x1 = EW'($signed(item_q.vx[1]));
    x2 = EW'($signed(item_q.vx[2]));
    y0 = EW'($signed(item_q.vy[0]));
    y1 = EW'($signed(item_q.vy[1]));
    y2 = EW'($signed(item_q.vy[2]));
    ox_e   = $signed(EW'(item_q.ox));
    oy_e   = $signed(EW'(item_q.oy));
    ox_far = ox_e + $signed(EW'(Size));
    oy_far = oy_e + $signed(EW'(Size));
    // far tile edge belongs to the tile, so only strict compares separate
    lo_x = (x0 < ox_e) && (x1 < ox_e) && (x2 < ox_e);
    hi_x = (x0 > ox_far) && (x1 > ox_far) && (x2 > ox_far);
    lo_y = (y0 < oy_e) && (y1 < oy_e) && (y2 < oy_e);
    hi_y = (y0 > oy_far) && (y1 > oy_far) && (y2 > oy_far);

    setup_d.vx     = item_q.vx;
    setup_d.vy     = item_q.vy;
    setup_d.ox     = item_q.ox;
    setup_d.oy     = item_q.oy;
    // axis = (-ey, ex) for each edge
    setup_d.ax[0]  = y0 - y1;
    setup_d.ay[0]  = x1 - x0;
    setup_d.ax[1]  = y1 - y2;
    setup_d.ay[1]  = x2 - x1;
    setup_d.ax[2]  = y2 - y0;
    setup_d.ay[2]  = x0 - x2;
    setup_d.sep_xy = lo_x | hi_x | lo_y | hi_y;
  end

  assign setup_o = setup_q;

endmodule

>>> sv/tto_proj.sv
// projection stages: products on each edge axis, then interval end points
// depends on tto_pkg
module tto_proj import tto_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic [1:0] en_i,
  input  setup_t     setup_i,
  output span_t      span_o
);

  localparam logic [TW-1:0] Size = TW'(TILE_SIZE);

  mul_t  mul_d, mul_q;
  span_t span_d, span_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mul_q <= mul_d;
    end
    if (en_i[1]) begin
      span_q <= span_d;
    end
  end

  always_comb begin
    prod_t sz;
    sz = $signed(PW'(Size));
    for (int k = 0; k < NE; k++) begin
      mul_d.pvx[k] = PW'($signed(setup_i.vx[k])) * PW'($signed(setup_i.ax[k]));
      mul_d.pvy[k] = PW'($signed(setup_i.vy[k])) * PW'($signed(setup_i.ay[k]));
      mul_d.pox[k] = $signed(PW'(setup_i.ox)) * PW'($signed(setup_i.ax[k]));
      mul_d.poy[k] = $signed(PW'(setup_i.oy)) * PW'($signed(setup_i.ay[k]));
      mul_d.psx[k] = sz * PW'($signed(setup_i.ax[k]));
      mul_d.psy[k] = sz * PW'($signed(setup_i.ay[k]));
    end
    // opposite vertex of each edge: c for a->b, a for b->c, b for c->a
    mul_d.qvx[0] = PW'($signed(setup_i.vx[2])) * PW'($signed(setup_i.ax[0]));
    mul_d.qvy[0] = PW'($signed(setup_i.vy[2])) * PW'($signed(setup_i.ay[0]));
    mul_d.qvx[1] = PW'($signed(setup_i.vx[0])) * PW'($signed(setup_i.ax[1]));
    mul_d.qvy[1] = PW'($signed(setup_i.vy[0])) * PW'($signed(setup_i.ay[1]));
    mul_d.qvx[2] = PW'($signed(setup_i.vx[1])) * PW'($signed(setup_i.ax[2]));
    mul_d.qvy[2] = PW'($signed(setup_i.vy[1])) * PW'($signed(setup_i.ay[2]));
    mul_d.sep_xy = setup_i.sep_xy;
  end

  always_comb begin
    dot_t base, sx, sy, sx_lo, sy_lo, sx_hi, sy_hi;
    base  = '0;
    sx    = '0;
    sy    = '0;
    sx_lo = '0;
    sy_lo = '0;
    sx_hi = '0;
    sy_hi = '0;
    for (int k = 0; k < NE; k++) begin
      span_d.tri_p[k] = DW'(mul_q.pvx[k]) + DW'(mul_q.pvy[k]);
      span_d.tri_q[k] = DW'(mul_q.qvx[k]) + DW'(mul_q.qvy[k]);
      base  = DW'(mul_q.pox[k]) + DW'(mul_q.poy[k]);
      sx    = DW'(mul_q.psx[k]);
      sy    = DW'(mul_q.psy[k]);
      // tile corner offsets are 0 or size on each coordinate
      sx_lo = sx[DW-1] ? sx : '0;
      sx_hi = sx[DW-1] ? '0 : sx;
      sy_lo = sy[DW-1] ? sy : '0;
      sy_hi = sy[DW-1] ? '0 : sy;
      span_d.tile_lo[k] = base + sx_lo + sy_lo;
      span_d.tile_hi[k] = base + sx_hi + sy_hi;
    end
    span_d.sep_xy = mul_q.sep_xy;
  end

  assign span_o = span_q;

endmodule

>>> sv/tto_cmp.sv
// interval compare stage and result register
// depends on tto_pkg
module tto_cmp import tto_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  span_t span_i,
  output logic  overlaps_o
);

  logic          overlaps_d, overlaps_q;
  logic [NE-1:0] sep;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      // touching intervals do not separate
      sep[k] = ((span_i.tile_hi[k] < span_i.tri_p[k]) &&
                (span_i.tile_hi[k] < span_i.tri_q[k])) ||
               ((span_i.tri_p[k] < span_i.tile_lo[k]) &&
                (span_i.tri_q[k] < span_i.tile_lo[k]));
    end
    overlaps_d = !(span_i.sep_xy || (|sep));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      overlaps_q <= overlaps_d;
    end
  end

  assign overlaps_o = overlaps_q;

endmodule

>>> sv/triangle_tile_overlap_test.sv
// top level of the triangle / tile overlap test: stream ports, valid chain
// depends on tto_pkg, tto_setup, tto_proj, tto_cmp and assert_macros.svh

// Separating axis test of a triangle against a square screen tile of side
// TILE_SIZE (far edges inclusive). Takes one transaction per cycle while
// s_axis_tready_o is high, through five register stages: input register, edge
// setup, products, interval end points, compare and result register. When the
// output is not stalled, m_axis_tvalid_o rises as the transaction is loaded into
// the result register.
// Each stage holds its item while the stage after it is full and cannot move
// on, so bubbles close up; s_axis_tready_o is low only when all five stages are
// full and the output is stalled.
`include "assert_macros.svh"

module triangle_tile_overlap_test import tto_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
  // tile_origin_x, tile_origin_y
  input  logic [IN_DW-1:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // overlaps, then zero padding
  output logic [OUT_DW-1:0] m_axis_tdata_o
);

  logic [NSTG-1:0] vld_d, vld_q;
  logic [NSTG:0]   rdy;
  item_t           item;
  setup_t          setup;
  span_t           span;
  logic            overlaps;

  assign item.vx[0] = s_axis_tdata_i[15:0];
  assign item.vy[0] = s_axis_tdata_i[31:16];
  assign item.vx[1] = s_axis_tdata_i[47:32];
  assign item.vy[1] = s_axis_tdata_i[63:48];
  assign item.vx[2] = s_axis_tdata_i[79:64];
  assign item.vy[2] = s_axis_tdata_i[95:80];
  assign item.ox    = s_axis_tdata_i[107:96];
  assign item.oy    = s_axis_tdata_i[119:108];

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    rdy[NSTG] = m_axis_tready_i;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    vld_d = {vld_q[NSTG-2:0], s_axis_tvalid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  tto_setup #(
    .TILE_SIZE(TILE_SIZE)
  ) u_setup (
    .clk_i  (clk_i),
    .en_i   (rdy[1:0]),
    .item_i (item),
    .setup_o(setup)
  );

  tto_proj #(
    .TILE_SIZE(TILE_SIZE)
  ) u_proj (
    .clk_i  (clk_i),
    .en_i   (rdy[3:2]),
    .setup_i(setup),
    .span_o (span)
  );

  tto_cmp u_cmp (
    .clk_i     (clk_i),
    .en_i      (rdy[4]),
    .span_i    (span),
    .overlaps_o(overlaps)
  );

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = vld_q[NSTG-1];
  assign m_axis_tdata_o  = {{(OUT_DW-1){1'b0}}, overlaps};

  `TTO_ASSERT_IMP(a_backpressure_full, !s_axis_tready_o,
    m_axis_tvalid_o && !m_axis_tready_i && (&vld_q), "input stalled with a free stage")
  `TTO_ASSERT_NXT(a_accept_loads, s_axis_tvalid_i && s_axis_tready_o,
    vld_q[0], "accepted transaction not in the input stage")
  `TTO_ASSERT_NXT(a_sum_to_out, vld_q[NSTG-2] && rdy[NSTG-1],
    m_axis_tvalid_o, "item lost between compare and result register")

endmodule

>>> tb/tto_overlap_checker.sv
// scoreboard for the triangle / tile overlap test: predicts overlaps per input transaction
// and compares it with each output transaction in order
// depends on tto_pkg
`timescale 1ns / 100ps

module tto_overlap_checker import tto_pkg::*; #(
  parameter int TILE = TILE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [IN_DW-1:0]  s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [OUT_DW-1:0] m_tdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  bit overlap_q[$];
  int fails;
  int results;

  // separating axis test on the x axis, the y axis and each edge normal
  function automatic bit overlap_predict(logic [IN_DW-1:0] d);
    coord_t vx[3];
    coord_t vy[3];
    logic [OW-1:0] ox;
    logic [OW-1:0] oy;
    longint cx[4];
    longint cy[4];
    longint nx, ny, p, qlo, qhi, tlo, thi;
    int k, n;
    for (int i = 0; i < 3; i++) begin
      vx[i] = d[32*i +: CW];
      vy[i] = d[32*i+CW +: CW];
    end
    ox = d[6*CW +: OW];
    oy = d[6*CW+OW +: OW];
    // far edges of the tile are inclusive
    cx[0] = ox;        cy[0] = oy;
    cx[1] = ox + TILE; cy[1] = oy;
    cx[2] = ox + TILE; cy[2] = oy + TILE;
    cx[3] = ox;        cy[3] = oy + TILE;
    for (int a = 0; a < 5; a++) begin
      if (a == 0) begin
        nx = 1; ny = 0;
      end else if (a == 1) begin
        nx = 0; ny = 1;
      end else begin
        k = a - 2;
        n = (k + 1) % 3;
        nx = -(longint'(vy[n]) - longint'(vy[k]));
        ny = longint'(vx[n]) - longint'(vx[k]);
      end
      qlo = cx[0] * nx + cy[0] * ny;
      qhi = qlo;
      for (int i = 1; i < 4; i++) begin
        p = cx[i] * nx + cy[i] * ny;
        if (p < qlo) qlo = p;
        if (p > qhi) qhi = p;
      end
      tlo = longint'(vx[0]) * nx + longint'(vy[0]) * ny;
      thi = tlo;
      for (int i = 1; i < 3; i++) begin
        p = longint'(vx[i]) * nx + longint'(vy[i]) * ny;
        if (p < tlo) tlo = p;
        if (p > thi) thi = p;
      end
      // touching intervals still count as overlap
      if (qhi < tlo || thi < qlo) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      overlap_q.delete();
      fails = 0;
      results = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // pop before push: an output transaction can never match an input taken this edge
      if (m_tvalid_i && m_tready_i) begin
        if (overlap_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("result %0d: unexpected transaction, overlaps=%0b", results, m_tdata_i[0]);
        end else begin
          want = overlap_q.pop_front();
          if (m_tdata_i[0] !== want) begin
            fails++;
            if (fails <= 10)
              $display("result %0d: overlaps expected %0b, got %0b",
                       results, want, m_tdata_i[0]);
          end
        end
        results++;
      end
      if (s_tvalid_i && s_tready_i)
        overlap_q.push_back(overlap_predict(s_tdata_i));
      fail_count_o <= fails;
      pending_o <= overlap_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// testbench top for triangle_tile_overlap_test: clock, reset, stimulus and verdict
// depends on tto_pkg, the block and tto_overlap_checker
`timescale 1ns / 100ps

module tb;
  import tto_pkg::*;

  localparam int TILE        = TILE_SIZE_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [OW-1:0] origin_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic [IN_DW-1:0]  s_tdata = '0;
  logic              m_tready = 1'b0;
  logic              s_tready;
  logic              m_tvalid;
  logic [OUT_DW-1:0] m_tdata;

  int send_idle_pct = 38;
  int recv_idle_pct = 66;
  int cycles = 0;
  int fail_count;
  int pending;

  triangle_tile_overlap_test #(
    .TILE_SIZE(TILE)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  tto_overlap_checker #(
    .TILE(TILE)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // tdata from the lowest bit up: a.x, a.y, b.x, b.y, c.x, c.y, origin x, origin y
  function automatic logic [IN_DW-1:0] pack_item(int ax, int ay, int bx, int by,
                                                  int cx, int cy, int ox, int oy);
    return {origin_t'(oy), origin_t'(ox), coord_t'(cy), coord_t'(cx),
            coord_t'(by), coord_t'(bx), coord_t'(ay), coord_t'(ax)};
  endfunction

  task automatic send(input logic [IN_DW-1:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic int jitter(int base, int spread);
    return base + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // mostly triangles near the tile so that every axis gets to decide
  function automatic logic [IN_DW-1:0] random_item();
    int v[6];
    int ox, oy, mode, spread, src, dst;
    ox = $urandom_range(0, 4095);
    oy = $urandom_range(0, 4095);
    if ($urandom_range(0, 7) == 0) ox = $urandom_range(0, 1) ? 4095 : 0;
    if ($urandom_range(0, 7) == 0) oy = $urandom_range(0, 1) ? 4095 : 0;
    mode = $urandom_range(0, 9);
    spread = (mode >= 7 && mode <= 8) ? 2000 : 3 * TILE;
    for (int i = 0; i < 6; i++) begin
      if (mode <= 1) v[i] = $urandom_range(0, 65535);
      else v[i] = jitter(((i % 2) ? oy : ox) + TILE / 2, spread);
    end
    // degenerate: one vertex lands on another
    if (mode == 9) begin
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      v[2*dst] = v[2*src];
      v[2*dst+1] = v[2*src+1];
    end
    return pack_item(v[0], v[1], v[2], v[3], v[4], v[5], ox, oy);
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // inside, clear of each side, and touching the tile edges
    send(pack_item(104, 204, 110, 204, 104, 210, 100, 200));
    send(pack_item(50, 200, 60, 210, 70, 205, 100, 200));
    send(pack_item(100, 230, 110, 240, 105, 250, 100, 200));
    send(pack_item(116, 216, 116, 216, 116, 216, 100, 200));
    send(pack_item(117, 216, 117, 216, 117, 216, 100, 200));
    send(pack_item(90, 200, 100, 205, 90, 210, 100, 200));
    send(pack_item(100, 199, 110, 199, 105, 180, 100, 200));
    // bounding boxes meet but an edge normal separates, both windings, then one that only touches
    send(pack_item(30, 10, 10, 30, 40, 40, 0, 0));
    send(pack_item(10, 30, 30, 10, 40, 40, 0, 0));
    send(pack_item(24, 8, 8, 24, 40, 40, 0, 0));
    // zero-length edges
    send(pack_item(-10, -10, -10, -10, 30, 30, 0, 0));
    send(pack_item(20, -30, -30, 20, 20, -30, 0, 0));
    send(pack_item(8, 8, 8, 8, 8, 8, 0, 0));
    // coordinate and origin extremes
    send(pack_item(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
    send(pack_item(32767, 32767, 32767, 32767, 32767, 32767, 4095, 4095));
    send(pack_item(-32768, -32768, 32767, -32768, -32768, 32767, 4095, 4095));
    send(pack_item(32767, 32767, -32768, 32767, 32767, -32768, 0, 0));
    send(pack_item(-32768, 32767, 32767, -32768, 0, 0, 4095, 0));
    send(pack_item(4111, 4111, 4111, 4111, 4111, 4111, 4095, 4095));
    send(pack_item(4112, 4111, 4112, 4111, 4112, 4111, 4095, 4095));
    send(pack_item(-1, 4095, 0, 4200, -20, 4200, 0, 4095));

    repeat (480) send(random_item());
    send_idle_pct = 66;
    recv_idle_pct = 38;
    repeat (480) send(random_item());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (490) send(random_item());
    s_tvalid <= 1'b0;

    // the checker's pending count is registered, so it trails the last transaction
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4 * NSTG) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
